>>> hw/rtl/pip_pkg.sv
// Shared types and constants for the point-in-polygon tester.
package pip_pkg;

    // Field widths of the stream payloads
    localparam int ACTION_W   = 2;
    localparam int COORD_W    = 16;
    localparam int HELD_W     = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // Item actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_TAIL  = 6'b000100,
        S_CLOSE = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

endpackage

>>> hw/rtl/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry and read one entry, with the read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/point_in_polygon_test.sv
// Point-in-polygon tester top level: vertex store, edge walk and even-odd crossing count.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | action, x_coord, y_coord (one per item)
//  m_axis   | out | m_axis_tvalid/tready   | inside_res, status, vertices_held
//
//  Clear, append and unused actions, and a query on an empty polygon, go from
//  acceptance straight to the done state and then to the output register. A query
//  over stored vertices walks the vertex RAM, reading one vertex per cycle, then
//  feeds the closing edge into a three-stage edge pipeline and waits for it to drain;
//  edges that miss the point's y span leave the pipeline after its first stage.
//  rst_n clears the vertex count and all control; the RAM contents are not cleared.
//  One item is in work at a time; an item may be accepted while a result waits
//  in the output register, and it finishes once that register frees.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] action, [17:2] x_coord, [33:18] y_coord, [39:34] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] inside_res, [1] status, [8:2] vertices_held, [15:9] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;

    // Input fields
    logic [ACTION_W-1:0]      act_in;
    logic [COORD_W-1:0]       x_field;
    logic [COORD_W-1:0]       y_field;
    logic signed [CW-1:0]     x_in;
    logic signed [CW-1:0]     y_in;

    assign act_in  = s_axis_tdata[ACTION_W-1:0];
    assign x_field = s_axis_tdata[ACTION_W +: COORD_W];
    assign y_field = s_axis_tdata[ACTION_W + COORD_W +: COORD_W];

    // Bring coordinates to the internal width
    generate
        if (CW <= COORD_W)
        begin : g_coord_trunc
            assign x_in = $signed(x_field[CW-1:0]);
            assign y_in = $signed(y_field[CW-1:0]);
        end
        else
        begin : g_coord_ext
            assign x_in = $signed({{(CW - COORD_W){1'b0}}, x_field});
            assign y_in = $signed({{(CW - COORD_W){1'b0}}, y_field});
        end
    endgenerate

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              ram_vld_reg;
    logic              first_pend_reg;
    logic              e_vld_reg, d_vld_reg, m_vld_reg;
    logic              par_reg;
    logic              status_reg;
    logic              out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Payload state
    logic signed [CW-1:0] px_reg, py_reg;
    logic [2*CW-1:0]      prev_reg, first_reg;
    logic [2*CW-1:0]      e_a_reg, e_b_reg;
    logic signed [DW-1:0] t_reg, dxe_reg, pxa_reg, dy_reg;
    logic signed [PW-1:0] lhs_reg, rhs_reg;

    // Handshake and decode
    logic in_acc;
    logic out_free;
    logic mem_we;
    logic rd_issue;
    logic [2*CW-1:0] ram_rdata;
    logic [HELD_W-1:0] held;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign mem_we        = in_acc && (act_in == ACT_APPEND) &&
                           (cnt_reg < CNT_W'(MAX_VERTICES));
    assign rd_issue      = (state_reg == S_WALK);

    generate
        if (CNT_W >= HELD_W)
        begin : g_held_trunc
            assign held = cnt_reg[HELD_W-1:0];
        end
        else
        begin : g_held_ext
            assign held = {{(HELD_W - CNT_W){1'b0}}, cnt_reg};
        end
    endgenerate

    // Vertex store, x in the low half, y in the high half
    pip_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata ({y_in, x_in}),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Sequence the item
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if ((act_in == ACT_QUERY) && (cnt_reg != '0))
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK:
            begin
                if (rd_idx_reg == cnt_reg - CNT_W'(1))
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:  state_next = S_CLOSE;
            S_CLOSE: state_next = S_DRAIN;
            S_DRAIN:
            begin
                if (!e_vld_reg && !d_vld_reg && !m_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Edge injection: walked edges, then the closing edge back to vertex 0
    logic            inj_vld;
    logic [2*CW-1:0] inj_b;

    assign inj_vld = (ram_vld_reg && !first_pend_reg) || (state_reg == S_CLOSE);
    assign inj_b   = (state_reg == S_CLOSE) ? first_reg : ram_rdata;

    // Orient the edge and build the differences
    logic signed [CW-1:0] ex1, ey1, ex2, ey2;
    logic signed [CW-1:0] xa, ya, xb, yb;
    logic                 edge_horiz, edge_span;

    always_comb
    begin
        ex1 = $signed(e_a_reg[CW-1:0]);
        ey1 = $signed(e_a_reg[2*CW-1:CW]);
        ex2 = $signed(e_b_reg[CW-1:0]);
        ey2 = $signed(e_b_reg[2*CW-1:CW]);
        if (ey1 < ey2)
        begin
            xa = ex1;
            ya = ey1;
            xb = ex2;
            yb = ey2;
        end
        else
        begin
            xa = ex2;
            ya = ey2;
            xb = ex1;
            yb = ey1;
        end
        edge_horiz = (ey1 == ey2);
        edge_span  = (py_reg >= ya) && (py_reg < yb);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            rd_idx_reg     <= '0;
            ram_vld_reg    <= 1'b0;
            first_pend_reg <= 1'b0;
            e_vld_reg      <= 1'b0;
            d_vld_reg      <= 1'b0;
            m_vld_reg      <= 1'b0;
            par_reg        <= 1'b0;
            status_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ram_vld_reg <= rd_issue;
            e_vld_reg   <= inj_vld;
            d_vld_reg   <= e_vld_reg && !edge_horiz && edge_span;
            m_vld_reg   <= d_vld_reg;

            // Take an item: update the count, start the walk
            if (in_acc)
            begin
                par_reg        <= 1'b0;
                status_reg     <= 1'b0;
                rd_idx_reg     <= '0;
                first_pend_reg <= (act_in == ACT_QUERY);
                case (act_in)
                    ACT_CLEAR: cnt_reg <= '0;
                    ACT_APPEND:
                    begin
                        if (mem_we)
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            status_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            else
            begin
                // Advance the read address
                if (rd_issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                if (ram_vld_reg)
                begin
                    first_pend_reg <= 1'b0;
                end
                // Toggle parity on a crossing right of the point
                if (m_vld_reg && (lhs_reg > rhs_reg))
                begin
                    par_reg <= !par_reg;
                end
            end

            // Hold the result until the sink takes it
            if ((state_reg == S_DONE) && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            px_reg <= x_in;
            py_reg <= y_in;
        end
        if (ram_vld_reg)
        begin
            prev_reg <= ram_rdata;
            if (first_pend_reg)
            begin
                first_reg <= ram_rdata;
            end
        end
        if (inj_vld)
        begin
            e_a_reg <= prev_reg;
            e_b_reg <= inj_b;
        end
        t_reg   <= DW'(py_reg) - DW'(ya);
        dxe_reg <= DW'(xb) - DW'(xa);
        pxa_reg <= DW'(px_reg) - DW'(xa);
        dy_reg  <= DW'(yb) - DW'(ya);
        lhs_reg <= PW'(t_reg) * PW'(dxe_reg);
        rhs_reg <= PW'(pxa_reg) * PW'(dy_reg);
        if ((state_reg == S_DONE) && out_free)
        begin
            out_data_reg <= {{(OUT_DATA_W - HELD_W - 2){1'b0}}, held, status_reg, par_reg};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // Count stays within the store
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    // Walk reads only stored vertices
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_issue |-> (rd_idx_reg < cnt_reg))
        else $error("walk read beyond stored vertices");

    // Edge pipeline is empty whenever a new item may enter
    a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!e_vld_reg && !d_vld_reg && !m_vld_reg && !ram_vld_reg))
        else $error("edge pipeline busy while idle");

    // A finished item reaches the output register
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> m_axis_tvalid)
        else $error("result not presented");

    // The store is written only while the count grows
    a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("vertex write without count update");

endmodule
